/* design/q24alu_pkg.sv */
// Shared types and constants for the Q24.8 fixed-point ALU.
// Every design file but q24alu_if imports this package; it depends on nothing.
`default_nettype none

package q24alu_pkg;

   localparam int FRACTION_BITS_DEF = 8;
   localparam int DATA_W            = 32;
   // Multiplier result lines up with the lane after this many registers
   localparam int MUL_STAGES        = 3;

   localparam logic [DATA_W-1:0] RAW_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] RAW_MIN = 32'h8000_0000;

   typedef enum logic [3:0] {
      KIND_ADD      = 4'd0,
      KIND_SUB      = 4'd1,
      KIND_MUL      = 4'd2,
      KIND_DIV      = 4'd3,
      KIND_GT       = 4'd4,
      KIND_LT       = 4'd5,
      KIND_GE       = 4'd6,
      KIND_LE       = 4'd7,
      KIND_EQ       = 4'd8,
      KIND_NE       = 4'd9,
      KIND_MIN      = 4'd10,
      KIND_MAX      = 4'd11,
      KIND_INC      = 4'd12,
      KIND_DEC      = 4'd13,
      KIND_FROM_INT = 4'd14,
      KIND_TO_INT   = 4'd15
   } kind_type;

   // Per-item control and partial results carried down the pipeline
   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] val;
      logic              truth;
      logic              err;
      logic              quo_neg;   // operand signs differ
      logic              a_neg;
      logic              b_zero;
      logic [DATA_W-1:0] div_d;     // |operand_b|
      logic [DATA_W-1:0] div_rem;   // running partial remainder
   } lane_type;

endpackage

`default_nettype wire

/* design/q24alu_if.sv */
// Valid/ready channel interfaces for the request and response sides of the ALU.
// Stand-alone: no package dependency.
`default_nettype none

interface q24alu_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         kind;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, output kind, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input kind, input operand_a, input operand_b,
                   output ready);
endinterface

interface q24alu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               truth;
   logic               error;

   modport source (output valid, output value, output truth, output error,
                   input ready);
   modport sink   (input valid, input value, input truth, input error,
                   output ready);
endinterface

`default_nettype wire

/* design/q24alu_front.sv */
// Entry stage: decodes the operation, computes the operations other than multiply
// and divide, and prepares operand magnitudes for the multiplier and divider. Uses q24alu_pkg.
`default_nettype none

module q24alu_front #(
   parameter int FRACTION_BITS = q24alu_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      en,
   input  wire logic                                      in_valid,
   input  wire logic [3:0]                                in_kind,
   input  wire logic signed [q24alu_pkg::DATA_W-1:0]      in_a,
   input  wire logic signed [q24alu_pkg::DATA_W-1:0]      in_b,
   output logic                                           out_valid,
   output q24alu_pkg::lane_type                           out_lane,
   output logic [q24alu_pkg::DATA_W+FRACTION_BITS-1:0]    out_num
);
   import q24alu_pkg::*;

   localparam int NUM_W = DATA_W + FRACTION_BITS;

   logic                    valid_ff, valid_in;
   lane_type                lane_ff, lane_in;
   logic [NUM_W-1:0]        num_ff, num_in;

   logic signed [DATA_W:0]  sum, diff, incr, decr;
   logic [DATA_W:0]         sat_sum, sat_diff, sat_incr, sat_decr;
   logic [FRACTION_BITS:0]  a_top;
   logic                    shl_ovf;
   logic [DATA_W-1:0]       mag_a, mag_b, shl_a, shr_a;
   logic                    gt, lt, eq;
   kind_type                kind;

   // Clamp a 33-bit signed sum to 32 bits; returns {error, value}
   function automatic logic [DATA_W:0] sat33(input logic signed [DATA_W:0] v);
      logic [DATA_W:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = {1'b1, (v[DATA_W] ? RAW_MIN : RAW_MAX)};
      end else begin
         r = {1'b0, v[DATA_W-1:0]};
      end
      return r;
   endfunction

   always_comb begin
      kind     = kind_type'(in_kind);
      sum      = {in_a[DATA_W-1], in_a} + {in_b[DATA_W-1], in_b};
      diff     = {in_a[DATA_W-1], in_a} - {in_b[DATA_W-1], in_b};
      incr     = {in_a[DATA_W-1], in_a} + (DATA_W+1)'(1);
      decr     = {in_a[DATA_W-1], in_a} - (DATA_W+1)'(1);
      sat_sum  = sat33(sum);
      sat_diff = sat33(diff);
      sat_incr = sat33(incr);
      sat_decr = sat33(decr);

      // Shift left overflows unless the dropped bits and the new sign agree
      a_top    = in_a[DATA_W-1 -: FRACTION_BITS+1];
      shl_ovf  = !((&a_top) || (~|a_top));
      shl_a    = DATA_W'(in_a <<< FRACTION_BITS);
      shr_a    = DATA_W'(in_a >>> FRACTION_BITS);

      gt = in_a > in_b;
      lt = in_a < in_b;
      eq = in_a == in_b;

      mag_a = in_a[DATA_W-1] ? (~in_a + DATA_W'(1)) : in_a;
      mag_b = in_b[DATA_W-1] ? (~in_b + DATA_W'(1)) : in_b;

      lane_in         = '0;
      lane_in.kind    = kind;
      lane_in.quo_neg = in_a[DATA_W-1] ^ in_b[DATA_W-1];
      lane_in.a_neg   = in_a[DATA_W-1];
      lane_in.b_zero  = (in_b == '0);
      lane_in.div_d   = mag_b;
      lane_in.div_rem = '0;
      num_in          = {mag_a, FRACTION_BITS'(0)};

      case (kind)
         KIND_ADD: begin
            lane_in.val = sat_sum[DATA_W-1:0];
            lane_in.err = sat_sum[DATA_W];
         end
         KIND_SUB: begin
            lane_in.val = sat_diff[DATA_W-1:0];
            lane_in.err = sat_diff[DATA_W];
         end
         KIND_GT:  lane_in.truth = gt;
         KIND_LT:  lane_in.truth = lt;
         KIND_GE:  lane_in.truth = !lt;
         KIND_LE:  lane_in.truth = !gt;
         KIND_EQ:  lane_in.truth = eq;
         KIND_NE:  lane_in.truth = !eq;
         KIND_MIN: lane_in.val = gt ? in_b : in_a;
         KIND_MAX: lane_in.val = lt ? in_b : in_a;
         KIND_INC: begin
            lane_in.val = sat_incr[DATA_W-1:0];
            lane_in.err = sat_incr[DATA_W];
         end
         KIND_DEC: begin
            lane_in.val = sat_decr[DATA_W-1:0];
            lane_in.err = sat_decr[DATA_W];
         end
         KIND_FROM_INT: begin
            lane_in.err = shl_ovf;
            if (shl_ovf) begin
               lane_in.val = in_a[DATA_W-1] ? RAW_MIN : RAW_MAX;
            end else begin
               lane_in.val = shl_a;
            end
         end
         KIND_TO_INT: lane_in.val = shr_a;
         default: begin
            // multiply and divide finish further down the pipeline
            lane_in.val = '0;
         end
      endcase

      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         num_ff  <= num_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_num   = num_ff;

endmodule

`default_nettype wire

/* design/q24alu_mul.sv */
// Three-stage magnitude multiplier with round-half-away and saturation.
// Runs beside the first divider steps; uses q24alu_pkg.
`default_nettype none

module q24alu_mul #(
   parameter int FRACTION_BITS = q24alu_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      en,
   input  q24alu_pkg::lane_type                           in_lane,
   input  wire logic [q24alu_pkg::DATA_W+FRACTION_BITS-1:0] in_num,
   output logic [q24alu_pkg::DATA_W-1:0]                  out_val,
   output logic                                           out_err
);
   import q24alu_pkg::*;

   localparam int NUM_W  = DATA_W + FRACTION_BITS;
   localparam int PROD_W = 2 * DATA_W;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              neg1_ff;
   logic [PROD_W-1:0] mag_ff, mag_in;
   logic              neg2_ff;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              err_ff, err_in;

   always_comb begin
      prod_in = PROD_W'(in_num[NUM_W-1 -: DATA_W]) * PROD_W'(in_lane.div_d);
      mag_in  = (prod_ff + (PROD_W'(1) << (FRACTION_BITS-1))) >> FRACTION_BITS;

      err_in = 1'b0;
      if (neg2_ff) begin
         if (mag_ff > PROD_W'(RAW_MIN)) begin
            val_in = RAW_MIN;
            err_in = 1'b1;
         end else begin
            val_in = ~mag_ff[DATA_W-1:0] + DATA_W'(1);
         end
      end else begin
         if (mag_ff > PROD_W'(RAW_MAX)) begin
            val_in = RAW_MAX;
            err_in = 1'b1;
         end else begin
            val_in = mag_ff[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         neg1_ff <= in_lane.quo_neg;
         mag_ff  <= mag_in;
         neg2_ff <= neg1_ff;
         val_ff  <= val_in;
         err_ff  <= err_in;
      end
   end

   assign out_val = val_ff;
   assign out_err = err_ff;

endmodule

`default_nettype wire

/* design/q24alu_div_step.sv */
// One restoring-division step: produces one quotient bit per register stage.
// Instantiated once per numerator bit by the top level; uses q24alu_pkg.
`default_nettype none

module q24alu_div_step #(
   parameter int FRACTION_BITS = q24alu_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      en,
   input  wire logic                                      in_valid,
   input  q24alu_pkg::lane_type                           in_lane,
   input  wire logic [q24alu_pkg::DATA_W+FRACTION_BITS-1:0] in_num,
   output logic                                           out_valid,
   output q24alu_pkg::lane_type                           out_lane,
   output logic [q24alu_pkg::DATA_W+FRACTION_BITS-1:0]    out_num
);
   import q24alu_pkg::*;

   localparam int NUM_W = DATA_W + FRACTION_BITS;

   logic              valid_ff;
   lane_type          lane_ff, lane_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DATA_W:0]   trial, trial_diff;
   logic              q_bit;

   always_comb begin
      // Bring down the next numerator bit and try the subtract
      trial      = {in_lane.div_rem, in_num[NUM_W-1]};
      trial_diff = trial - {1'b0, in_lane.div_d};
      q_bit      = (trial >= {1'b0, in_lane.div_d});

      lane_in         = in_lane;
      lane_in.div_rem = q_bit ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
      num_in          = {in_num[NUM_W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         num_ff  <= num_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_num   = num_ff;

endmodule

`default_nettype wire

/* design/q24alu_back.sv */
// Tail of the pipeline: quotient rounding, divide saturation, result select,
// the output register and the pipeline advance control. Uses q24alu_pkg and q24alu_rsp_if.
`default_nettype none

module q24alu_back #(
   parameter int FRACTION_BITS = q24alu_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      in_valid,
   input  q24alu_pkg::lane_type                           in_lane,
   input  wire logic [q24alu_pkg::DATA_W+FRACTION_BITS-1:0] in_num,
   output logic                                           en,
   q24alu_rsp_if.source                                   rsp_bus
);
   import q24alu_pkg::*;

   localparam int NUM_W = DATA_W + FRACTION_BITS;

   logic              rnd_valid_ff;
   lane_type          rnd_lane_ff;
   logic [NUM_W:0]    quo_ff, quo_in;
   logic              rnd_up;

   logic              out_valid_ff;
   logic [DATA_W-1:0] value_ff, value_in;
   logic              truth_ff, truth_in;
   logic              error_ff, error_in;
   logic              out_load;

   // Advance while the tail has a bubble or the held result is being taken
   assign out_load = !out_valid_ff || rsp_bus.ready;
   assign en       = out_load || !rnd_valid_ff;

   always_comb begin
      // Round half up on the magnitude: bump when twice the remainder reaches the divisor
      rnd_up = ({in_lane.div_rem, 1'b0} >= {1'b0, in_lane.div_d});
      quo_in = {1'b0, in_num} + (NUM_W+1)'(rnd_up);
   end

   always_comb begin
      value_in = rnd_lane_ff.val;
      truth_in = rnd_lane_ff.truth;
      error_in = rnd_lane_ff.err;
      case (rnd_lane_ff.kind)
         KIND_DIV: begin
            truth_in = 1'b0;
            if (rnd_lane_ff.b_zero) begin
               error_in = 1'b1;
               value_in = rnd_lane_ff.a_neg ? RAW_MIN : RAW_MAX;
            end else if (rnd_lane_ff.quo_neg) begin
               if (quo_ff > (NUM_W+1)'(RAW_MIN)) begin
                  error_in = 1'b1;
                  value_in = RAW_MIN;
               end else begin
                  error_in = 1'b0;
                  value_in = ~quo_ff[DATA_W-1:0] + DATA_W'(1);
               end
            end else begin
               if (quo_ff > (NUM_W+1)'(RAW_MAX)) begin
                  error_in = 1'b1;
                  value_in = RAW_MAX;
               end else begin
                  error_in = 1'b0;
                  value_in = quo_ff[DATA_W-1:0];
               end
            end
         end
         default: begin
            value_in = rnd_lane_ff.val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            rnd_valid_ff <= in_valid;
         end
         if (out_load) begin
            out_valid_ff <= rnd_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rnd_lane_ff <= in_lane;
         quo_ff      <= quo_in;
      end
      if (out_load) begin
         value_ff <= value_in;
         truth_ff <= truth_in;
         error_ff <= error_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.value = value_ff;
   assign rsp_bus.truth = truth_ff;
   assign rsp_bus.error = error_ff;

endmodule

`default_nettype wire

/* design/q24_8_fixed_point_alu.sv */
// Signed Q24.8 fixed-point ALU, fully pipelined: one item may be accepted every
// clock while the pipeline is not stalled, and each produces exactly one result
// in order. A request passes through one entry stage, one restoring-division
// step per numerator bit (32 + FRACTION_BITS steps), a rounding stage and the
// output register. Every operation takes the same path, so results never
// reorder; the multiplier runs beside the first three division steps. When the
// output register is held, the pipeline keeps advancing only while the rounding
// stage is empty; once that stage fills, the whole pipeline and the request
// side stall, even if bubbles remain in earlier stages. Multiply and divide round
// to nearest with halves away from zero; overflow saturates and sets error,
// and division by zero returns the bound matching the dividend's sign.
// Depends on q24alu_pkg, q24alu_if and the q24alu_* submodules.
`default_nettype none

module q24_8_fixed_point_alu #(
   parameter int FRACTION_BITS = q24alu_pkg::FRACTION_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   q24alu_req_if.sink   req_bus,
   q24alu_rsp_if.source rsp_bus
);
   import q24alu_pkg::*;

   localparam int NUM_W = DATA_W + FRACTION_BITS;

   logic              en;
   logic              valid_pipe [0:NUM_W];
   lane_type          lane_pipe  [0:NUM_W];
   logic [NUM_W-1:0]  num_pipe   [0:NUM_W];
   logic [DATA_W-1:0] mul_val;
   logic              mul_err;
   lane_type          lane_merged;

   assign req_bus.ready = en;

   q24alu_front #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .in_kind   (req_bus.kind),
      .in_a      (req_bus.operand_a),
      .in_b      (req_bus.operand_b),
      .out_valid (valid_pipe[0]),
      .out_lane  (lane_pipe[0]),
      .out_num   (num_pipe[0])
   );

   q24alu_mul #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mul (
      .clock   (clock),
      .en      (en),
      .in_lane (lane_pipe[0]),
      .in_num  (num_pipe[0]),
      .out_val (mul_val),
      .out_err (mul_err)
   );

   // Fold the product into the lane where the multiplier output lines up
   always_comb begin
      lane_merged = lane_pipe[MUL_STAGES];
      if (lane_pipe[MUL_STAGES].kind == KIND_MUL) begin
         lane_merged.val = mul_val;
         lane_merged.err = mul_err;
      end
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_div
      if (k == MUL_STAGES) begin : g_merge
         q24alu_div_step #(
            .FRACTION_BITS (FRACTION_BITS)
         ) u_step (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (valid_pipe[k]),
            .in_lane   (lane_merged),
            .in_num    (num_pipe[k]),
            .out_valid (valid_pipe[k+1]),
            .out_lane  (lane_pipe[k+1]),
            .out_num   (num_pipe[k+1])
         );
      end else begin : g_plain
         q24alu_div_step #(
            .FRACTION_BITS (FRACTION_BITS)
         ) u_step (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (valid_pipe[k]),
            .in_lane   (lane_pipe[k]),
            .in_num    (num_pipe[k]),
            .out_valid (valid_pipe[k+1]),
            .out_lane  (lane_pipe[k+1]),
            .out_num   (num_pipe[k+1])
         );
      end
   end

   q24alu_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_pipe[NUM_W]),
      .in_lane  (lane_pipe[NUM_W]),
      .in_num   (num_pipe[NUM_W]),
      .en       (en),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire
